/* rtl/yaw_frame_parser_macros.svh */
// Assertion macros for the files that check their own logic; yaw_frame_parser.sv uses them.
`ifndef YAW_FRAME_PARSER_MACROS_SVH
`define YAW_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("yaw_frame_parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define YFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("yaw_frame_parser: next-cycle check failed");

`endif

/* rtl/yfp_pkg.sv */
package yfp_pkg;

  localparam logic [7:0] HDR_BYTE      = 8'h55;
  localparam logic [7:0] TYPE_BYTE     = 8'h53;
  localparam logic [3:0] FIRST_BODY    = 4'd2;
  localparam logic [3:0] YAW_LO_IDX    = 4'd6;
  localparam logic [3:0] YAW_HI_IDX    = 4'd7;
  localparam logic [3:0] CHECKSUM_IDX  = 4'd10;

  typedef enum logic [1:0] {
    SYNC_HUNT    = 2'd0,
    SYNC_TYPE    = 2'd1,
    SYNC_COLLECT = 2'd2
  } sync_state_t;

  typedef struct packed {
    logic        done;
    logic [15:0] raw_u;
  } frame_evt_t;

endpackage

/* rtl/yfp_sync.sv */
module yfp_sync (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        rx_byte,
  output yfp_pkg::frame_evt_t evt
);

  yfp_pkg::sync_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] lo_r, lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic       done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= yfp_pkg::SYNC_HUNT;
      cnt_r   <= '0;
      sum_r   <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
    end else if (byte_vld) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    done      = 1'b0;
    case (state_r)
      yfp_pkg::SYNC_TYPE: begin
        if (rx_byte == yfp_pkg::TYPE_BYTE) begin
          sum_nxt   = sum_r + rx_byte;
          cnt_nxt   = yfp_pkg::FIRST_BODY;
          state_nxt = yfp_pkg::SYNC_COLLECT;
        end
      end
      yfp_pkg::SYNC_COLLECT: begin
        if (cnt_r < yfp_pkg::CHECKSUM_IDX) begin
          if (cnt_r == yfp_pkg::YAW_LO_IDX) lo_nxt = rx_byte;
          if (cnt_r == yfp_pkg::YAW_HI_IDX) hi_nxt = rx_byte;
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = cnt_r + 4'd1;
        end else begin
          done      = (sum_r == rx_byte);
          state_nxt = yfp_pkg::SYNC_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end
      end
      default: begin
        if (rx_byte == yfp_pkg::HDR_BYTE) begin
          sum_nxt   = rx_byte;
          cnt_nxt   = 4'd1;
          state_nxt = yfp_pkg::SYNC_TYPE;
        end else begin
          state_nxt = yfp_pkg::SYNC_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end
      end
    endcase
  end

  assign evt = '{done: byte_vld && done, raw_u: {hi_r, lo_r}};

endmodule

/* rtl/yaw_frame_parser.sv */
// One byte per cycle is accepted while the result side keeps up.
// A result becomes valid after the checksum byte is accepted: the
// byte sits in the input register until the result side is free,
// and the result register loads when that byte is processed.
// Synchronous active-low reset returns the parser to header hunt and
// clears the reference yaw, its taken flag and both valid flags.
`include "yaw_frame_parser_macros.svh"

module yaw_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] yaw_raw, [32:16] world_yaw, [39:33] zero
  output logic        out_tuser   // [0] reference_set_now
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r;
  logic        proc_go;
  yfp_pkg::frame_evt_t evt;

  logic [15:0] ref_r;
  logic        ref_taken_r;
  logic [15:0] ref_use;
  logic signed [17:0] diff;
  logic signed [17:0] wrapped;

  logic               out_vld_r, out_vld_nxt;
  logic [15:0]        yaw_raw_r;
  logic signed [16:0] world_yaw_r;
  logic               set_now_r;
  logic               world_ok;

  assign proc_go   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_go;

  always_comb begin
    in_vld_nxt = in_vld_r && !proc_go;
    if (in_tvalid && in_tready) in_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  yfp_sync u_sync (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (proc_go),
    .rx_byte  (in_byte_r),
    .evt      (evt)
  );

  assign ref_use = ref_taken_r ? ref_r : evt.raw_u;
  assign diff    = {{2{evt.raw_u[15]}}, evt.raw_u} - {{2{ref_use[15]}}, ref_use};

  always_comb begin
    wrapped = diff;
    if (diff > 18'sd32768) begin
      wrapped = diff - 18'sd65536;
    end else if (diff < -18'sd32768) begin
      wrapped = diff + 18'sd65536;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      ref_taken_r <= 1'b0;
    end else if (evt.done && !ref_taken_r) begin
      ref_r       <= evt.raw_u;
      ref_taken_r <= 1'b1;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (evt.done) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.done) begin
      yaw_raw_r   <= evt.raw_u;
      world_yaw_r <= wrapped[16:0];
      set_now_r   <= !ref_taken_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, world_yaw_r, yaw_raw_r};
  assign out_tuser  = set_now_r;

  assign world_ok = (world_yaw_r <= 17'sd32768) && (world_yaw_r >= -17'sd32768);

  `YFP_ASSERT_IMP(a_set_now_zero, clk, rst_n, out_vld_r && set_now_r, world_yaw_r == 17'sd0)
  `YFP_ASSERT_IMP(a_world_range, clk, rst_n, out_vld_r, world_ok)
  `YFP_ASSERT_NXT(a_ref_sticky, clk, rst_n, ref_taken_r, ref_taken_r && $stable(ref_r))
  `YFP_ASSERT_NXT(a_done_loads, clk, rst_n, evt.done, out_vld_r)

endmodule
